FILE: rtl/bsr_pkg.sv
package bsr_pkg;

    // Codepoints that steer the parser.
    localparam logic [20:0] CP_NUKTA   = 21'h009BC;
    localparam logic [20:0] CP_HALANT  = 21'h009CD;
    localparam logic [20:0] CP_RA      = 21'h009B0;
    localparam logic [20:0] CP_SIGN_E  = 21'h009C7;
    localparam logic [20:0] CP_ZWJ     = 21'h0200D;
    localparam logic [20:0] CP_ZWNJ    = 21'h0200C;
    localparam logic [20:0] CP_SIGN_O  = 21'h009CB;
    localparam logic [20:0] CP_SIGN_AU = 21'h009CC;
    localparam logic [20:0] CP_SIGN_AA = 21'h009BE;
    localparam logic [20:0] CP_AU_MARK = 21'h009D7;
    localparam logic [20:0] CP_DDA     = 21'h009A1;
    localparam logic [20:0] CP_RRA     = 21'h009DC;
    localparam logic [20:0] CP_DDHA    = 21'h009A2;
    localparam logic [20:0] CP_RHA     = 21'h009DD;
    localparam logic [20:0] CP_YA      = 21'h009AF;
    localparam logic [20:0] CP_YYA     = 21'h009DF;
    localparam logic [20:0] CP_SIGN_I  = 21'h009BF;
    localparam logic [20:0] CP_SIGN_AI = 21'h009C8;

    // Position within the current syllable.
    typedef enum logic [2:0] {
        PH_IDLE, PH_CONS, PH_NUK, PH_HAL, PH_HALZWJ, PH_TAIL, PH_RA, PH_RAHAL
    } t_phase;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE, S_COMP, S_RA1, S_RA2, S_START, S_FIN, S_FINIT,
        S_PRE_RD, S_PRE_EM, S_CL_RD, S_CL_EM, S_PO_RD, S_PO_EM
    } t_state;

    // What an accepted item does to the syllable.
    typedef enum logic [2:0] {
        A_PUSHC, A_PUSHT, A_CLOSE, A_REPH, A_START
    } t_act;

    function automatic logic is_cons(input logic [20:0] c);
        return (c >= 21'h00995 && c <= 21'h009B9) || c == 21'h009DC ||
               c == 21'h009DD || c == 21'h009DF || c == 21'h009F0 || c == 21'h009F1;
    endfunction

    function automatic logic is_tail(input logic [20:0] c);
        return (c >= 21'h00981 && c <= 21'h00983) || (c >= 21'h009BE && c <= 21'h009CC) ||
               c == 21'h009D7 || c == 21'h009E2 || c == 21'h009E3;
    endfunction

    function automatic logic [20:0] pre_part(input logic [20:0] c);
        if (c == CP_SIGN_I || c == CP_SIGN_AI) return c;
        if (c == CP_SIGN_E || c == CP_SIGN_O || c == CP_SIGN_AU) return CP_SIGN_E;
        return '0;
    endfunction

    function automatic logic [20:0] post_part(input logic [20:0] c);
        if (c == CP_SIGN_I || c == CP_SIGN_E || c == CP_SIGN_AI) return '0;
        if (c == CP_SIGN_O) return CP_SIGN_AA;
        if (c == CP_SIGN_AU) return CP_AU_MARK;
        return c;
    endfunction

    function automatic logic [20:0] nukta_form(input logic [20:0] c);
        if (c == CP_DDA) return CP_RRA;
        if (c == CP_DDHA) return CP_RHA;
        if (c == CP_YA) return CP_YYA;
        return '0;
    endfunction

endpackage

FILE: rtl/bsr_ram.sv
module bsr_ram #(
    parameter int WIDTH = 21,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/bengali_syllable_reorder.sv
// A codepoint that passes straight through goes via the hold stage to the output register.
// A buffered item holds the input while it is stored, and while a nukta that composes rewrites
// its consonant. A reph emits ra and halant first. A syllable flush takes a set-up step, then
// reads the tail memory twice and the cluster memory once, reading then emitting each stored
// entry; output stalls hold each emission. The input is stalled until the current item is done.
// Synchronous active-low reset empties the syllable.
module bengali_syllable_reorder import bsr_pkg::*; #(
    parameter int MAX_CLUSTER = 16,
    parameter int MAX_TAIL    = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [20:0] i_code_point,
    input  logic        i_text_end,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [20:0] o_out_point,
    output logic        o_run_last,
    output logic        o_text_changed
);

    localparam int CCW = $clog2(MAX_CLUSTER + 1);
    localparam int TCW = $clog2(MAX_TAIL + 1);
    localparam int CAW = $clog2(MAX_CLUSTER);
    localparam int TAW = (MAX_TAIL > 1) ? $clog2(MAX_TAIL) : 1;

    t_state          r_state, n_state;
    t_phase          r_phase, n_phase;
    logic [CCW-1:0]  r_ccount, n_ccount, r_ci, n_ci;
    logic [TCW-1:0]  r_tcount, n_tcount, r_ti, n_ti;
    logic            r_syl_chg, n_syl_chg, r_changed, n_changed;
    logic            r_ret, n_ret, r_last;
    logic [20:0]     r_last_cp, n_last_cp, r_cp;

    // Hold stage and output register.
    logic            r_hv, r_ov, r_ol, r_oc;
    logic [20:0]     r_hcp, r_op;

    logic            s_acc, s_out_free, s_hold_ok, s_drain, s_move;
    logic            s_emit;
    logic [20:0]     s_emit_cp;

    // Decision for the item at the input.
    t_act            s_act;
    t_phase          s_nph;
    logic            s_comp, s_cfull, s_tfull;

    // Memory ports.
    logic            c_we, c_re, t_we, t_re;
    logic [CAW-1:0]  c_wa, c_ra;
    logic [TAW-1:0]  t_wa, t_ra;
    logic [21:0]     c_wd, c_rd;
    logic [20:0]     t_rd;
    logic [CCW-1:0]  s_cm2;
    logic [20:0]     s_pre, s_post;

    bsr_ram #(.WIDTH(22), .DEPTH(MAX_CLUSTER)) u_cluster (
        .i_clk(i_clk), .i_we(c_we), .i_waddr(c_wa), .i_wdata(c_wd),
        .i_re(c_re), .i_raddr(c_ra), .o_rdata(c_rd)
    );

    bsr_ram #(.WIDTH(21), .DEPTH(MAX_TAIL)) u_tail (
        .i_clk(i_clk), .i_we(t_we), .i_waddr(t_wa), .i_wdata(i_code_point),
        .i_re(t_re), .i_raddr(t_ra), .o_rdata(t_rd)
    );

    assign s_acc      = i_valid && (r_state == S_IDLE);
    assign o_stall    = (r_state != S_IDLE);
    assign s_out_free = !r_ov || !i_stall;
    assign s_hold_ok  = !r_hv || s_out_free;
    assign s_cfull    = (r_ccount == CCW'(MAX_CLUSTER));
    assign s_tfull    = (r_tcount == TCW'(MAX_TAIL));
    assign s_pre      = pre_part(t_rd);
    assign s_post     = post_part(t_rd);
    assign s_cm2      = r_ccount - CCW'(2);

    // Parse the incoming codepoint against the current phase.
    always_comb begin
        logic c_nuk, c_hal, c_tl, c_cn;
        c_nuk  = (i_code_point == CP_NUKTA);
        c_hal  = (i_code_point == CP_HALANT);
        c_tl   = is_tail(i_code_point);
        c_cn   = is_cons(i_code_point);
        s_act  = A_CLOSE;
        s_nph  = PH_CONS;
        s_comp = 1'b0;
        unique case (r_phase)
            PH_CONS, PH_RA: begin
                if (c_nuk) begin
                    s_act  = A_PUSHC;
                    s_nph  = PH_NUK;
                    s_comp = (nukta_form(r_last_cp) != '0);
                end else if (c_hal) begin
                    s_act = A_PUSHC;
                    s_nph = (r_phase == PH_RA) ? PH_RAHAL : PH_HAL;
                end else if (c_tl) begin
                    s_act = A_PUSHT;
                end
            end
            PH_NUK: begin
                if (c_hal) begin
                    s_act = A_PUSHC;
                    s_nph = PH_HAL;
                end else if (c_tl) begin
                    s_act = A_PUSHT;
                end
            end
            PH_HAL, PH_RAHAL: begin
                if (c_cn) begin
                    s_act = (r_phase == PH_RAHAL) ? A_REPH : A_PUSHC;
                    s_nph = PH_CONS;
                end else if (i_code_point == CP_ZWJ) begin
                    s_act = A_PUSHC;
                    s_nph = PH_HALZWJ;
                end else if (i_code_point == CP_ZWNJ) begin
                    s_act = A_PUSHC;
                    s_nph = PH_TAIL;
                end else if (c_tl) begin
                    s_act = A_PUSHT;
                end
            end
            PH_HALZWJ: begin
                if (c_cn) begin
                    s_act = A_PUSHC;
                end else if (c_tl) begin
                    s_act = A_PUSHT;
                end
            end
            PH_TAIL: begin
                if (c_tl) begin
                    s_act = A_PUSHT;
                end
            end
            PH_IDLE: begin
                s_act = A_START;
            end
        endcase
        // A full store closes the syllable early.
        if (s_act == A_PUSHC && s_cfull) begin
            s_act = A_CLOSE;
        end
        if (s_act == A_PUSHT && s_tfull) begin
            s_act = A_CLOSE;
        end
    end

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    unique case (s_act)
                        A_PUSHC: n_state = s_comp ? S_COMP : S_FIN;
                        A_PUSHT: n_state = S_FIN;
                        A_CLOSE: n_state = S_FINIT;
                        A_REPH:  n_state = S_RA1;
                        A_START: n_state = S_START;
                        default: n_state = S_FIN;
                    endcase
                end
            end
            S_COMP:  n_state = S_FIN;
            S_RA1:   if (s_hold_ok) n_state = S_RA2;
            S_RA2:   if (s_hold_ok) n_state = S_FIN;
            S_START: if (is_cons(r_cp) || s_hold_ok) n_state = S_FIN;
            S_FIN: begin
                if (r_last && r_phase != PH_IDLE) begin
                    n_state = S_FINIT;
                end else if (!r_hv || s_out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_FINIT: n_state = S_PRE_RD;
            S_PRE_RD: n_state = (r_ti == r_tcount) ? S_CL_RD : S_PRE_EM;
            S_PRE_EM: if (s_pre == '0 || s_hold_ok) n_state = S_PRE_RD;
            S_CL_RD:  n_state = (r_ci == r_ccount) ? S_PO_RD : S_CL_EM;
            S_CL_EM:  if (c_rd[21] || s_hold_ok) n_state = S_CL_RD;
            S_PO_RD: begin
                if (r_ti == r_tcount) begin
                    n_state = r_ret ? S_START : S_FIN;
                end else begin
                    n_state = S_PO_EM;
                end
            end
            S_PO_EM: if (s_post == '0 || s_hold_ok) n_state = S_PO_RD;
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath, memory controls and emissions.
    always_comb begin
        n_phase   = r_phase;
        n_ccount  = r_ccount;
        n_tcount  = r_tcount;
        n_ci      = r_ci;
        n_ti      = r_ti;
        n_syl_chg = r_syl_chg;
        n_changed = r_changed;
        n_ret     = r_ret;
        n_last_cp = r_last_cp;
        c_we      = 1'b0;
        c_wa      = r_ccount[CAW-1:0];
        c_wd      = {1'b0, r_cp};
        c_re      = 1'b0;
        c_ra      = r_ci[CAW-1:0];
        t_we      = 1'b0;
        t_wa      = r_tcount[TAW-1:0];
        t_re      = 1'b0;
        t_ra      = r_ti[TAW-1:0];
        s_emit    = 1'b0;
        s_emit_cp = r_cp;
        unique case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    unique case (s_act)
                        A_PUSHC: begin
                            // A composing nukta is kept as a skipped entry.
                            c_we     = 1'b1;
                            c_wd     = {s_comp, i_code_point};
                            n_ccount = r_ccount + CCW'(1);
                            n_phase  = s_nph;
                            if (i_code_point != CP_NUKTA) begin
                                n_last_cp = i_code_point;
                            end
                            if (s_comp) begin
                                n_syl_chg = 1'b1;
                            end
                        end
                        A_PUSHT: begin
                            t_we     = 1'b1;
                            n_tcount = r_tcount + TCW'(1);
                            n_phase  = PH_TAIL;
                            if (pre_part(i_code_point) != '0) begin
                                n_syl_chg = 1'b1;
                            end
                        end
                        A_CLOSE: n_ret = 1'b1;
                        default: n_ret = 1'b0;
                    endcase
                end
            end
            S_COMP: begin
                // Overwrite the consonant with its composed letter.
                c_we = 1'b1;
                c_wa = s_cm2[CAW-1:0];
                c_wd = {1'b0, nukta_form(r_last_cp)};
            end
            S_RA1: begin
                s_emit    = s_hold_ok;
                s_emit_cp = CP_RA;
            end
            S_RA2: begin
                s_emit    = s_hold_ok;
                s_emit_cp = CP_HALANT;
                if (s_hold_ok) begin
                    c_we      = 1'b1;
                    c_wa      = '0;
                    n_ccount  = CCW'(1);
                    n_phase   = PH_CONS;
                    n_last_cp = r_cp;
                end
            end
            S_START: begin
                if (is_cons(r_cp)) begin
                    c_we      = 1'b1;
                    c_wa      = '0;
                    n_ccount  = CCW'(1);
                    n_tcount  = '0;
                    n_syl_chg = 1'b0;
                    n_last_cp = r_cp;
                    n_phase   = (r_cp == CP_RA) ? PH_RA : PH_CONS;
                end else begin
                    s_emit = s_hold_ok;
                end
            end
            S_FIN: begin
                if (r_last && r_phase != PH_IDLE) begin
                    n_ret = 1'b0;
                end else if ((!r_hv || s_out_free) && r_last) begin
                    n_changed = 1'b0;
                end
            end
            S_FINIT: begin
                n_changed = r_changed | r_syl_chg;
                n_ti      = '0;
            end
            S_PRE_RD: begin
                if (r_ti == r_tcount) begin
                    n_ci = '0;
                end else begin
                    t_re = 1'b1;
                end
            end
            S_PRE_EM: begin
                s_emit    = (s_pre != '0) && s_hold_ok;
                s_emit_cp = s_pre;
                if (s_pre == '0 || s_hold_ok) begin
                    n_ti = r_ti + TCW'(1);
                end
            end
            S_CL_RD: begin
                if (r_ci == r_ccount) begin
                    n_ti = '0;
                end else begin
                    c_re = 1'b1;
                end
            end
            S_CL_EM: begin
                s_emit    = !c_rd[21] && s_hold_ok;
                s_emit_cp = c_rd[20:0];
                if (c_rd[21] || s_hold_ok) begin
                    n_ci = r_ci + CCW'(1);
                end
            end
            S_PO_RD: begin
                if (r_ti == r_tcount) begin
                    n_ccount  = '0;
                    n_tcount  = '0;
                    n_phase   = PH_IDLE;
                    n_syl_chg = 1'b0;
                end else begin
                    t_re = 1'b1;
                end
            end
            S_PO_EM: begin
                s_emit    = (s_post != '0) && s_hold_ok;
                s_emit_cp = s_post;
                if (s_post == '0 || s_hold_ok) begin
                    n_ti = r_ti + TCW'(1);
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
    end

    // The held item goes out when a newer one arrives or the input item is finished.
    assign s_drain = (r_state == S_FIN) && !(r_last && r_phase != PH_IDLE);
    assign s_move  = r_hv && s_out_free && (s_emit || s_drain);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_phase   <= PH_IDLE;
            r_ccount  <= '0;
            r_tcount  <= '0;
            r_ci      <= '0;
            r_ti      <= '0;
            r_syl_chg <= 1'b0;
            r_changed <= 1'b0;
            r_ret     <= 1'b0;
            r_last    <= 1'b0;
            r_hv      <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_ccount  <= n_ccount;
            r_tcount  <= n_tcount;
            r_ci      <= n_ci;
            r_ti      <= n_ti;
            r_syl_chg <= n_syl_chg;
            r_changed <= n_changed;
            r_ret     <= n_ret;
            if (s_acc) begin
                r_last <= i_text_end;
            end
            if (s_emit) begin
                r_hv <= 1'b1;
            end else if (s_move) begin
                r_hv <= 1'b0;
            end
            if (s_move) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_last_cp <= n_last_cp;
        if (s_acc) begin
            r_cp <= i_code_point;
        end
        if (s_emit) begin
            r_hcp <= s_emit_cp;
        end
        if (s_move) begin
            r_op <= r_hcp;
            r_ol <= s_drain;
            r_oc <= r_changed;
        end
    end

    assign o_valid        = r_ov;
    assign o_out_point    = r_op;
    assign o_run_last     = r_ol;
    assign o_text_changed = r_oc;

    a_ccount_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ccount <= CCW'(MAX_CLUSTER))
        else $error("cluster count beyond store depth");

    a_tcount_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tcount <= TCW'(MAX_TAIL))
        else $error("tail count beyond store depth");

    a_idle_hold_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !r_hv)
        else $error("held item left behind when ready for input");

    a_idle_phase_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_phase == PH_IDLE) |-> (r_ccount == '0 && r_tcount == '0))
        else $error("buffered entries outside a syllable");

    a_open_has_cluster: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_phase != PH_IDLE) |-> (r_ccount != '0))
        else $error("open syllable without cluster");

endmodule
